// File: rtl/ordered_key_value_table_top_assert.svh
// Assertion macros used by the ordered key-value table datapath.
`ifndef ORDERED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OKVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("okvt same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("okvt next-cycle check failed");

`endif

// File: rtl/okvt_pkg.sv
// Shared types and constants for the ordered key-value table.
package okvt_pkg;

    // Operation kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;
    localparam logic [1:0] KIND_UPDATE = 2'd3;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic cmp;    // register the key compare vector
        logic exec;   // apply the operation and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;  // result register holds an undelivered result
    } t_stat;

endpackage

// File: rtl/okvt_ctrl.sv
// Controller state machine for the ordered key-value table.
module okvt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_m_tready,
    input  okvt_pkg::t_stat i_stat,
    output okvt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_out_free;
    logic       w_load;

    // The result register can take a new result this cycle.
    assign w_out_free = !i_stat.out_valid || i_m_tready;

    // A new request is taken when idle, or while the current one finishes.
    assign o_s_tready = (r_state == ST_IDLE) || ((r_state == ST_EXEC) && w_out_free);
    assign w_load     = i_s_tvalid && o_s_tready;

    assign o_cmd.load = w_load;
    assign o_cmd.cmp  = (r_state == ST_CMP);
    assign o_cmd.exec = (r_state == ST_EXEC) && w_out_free;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_out_free) n_state = w_load ? ST_CMP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/okvt_dp.sv
// Datapath for the ordered key-value table: entry cells, compare and result register.
`include "ordered_key_value_table_top_assert.svh"

module okvt_dp #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  okvt_pkg::t_cmd               i_cmd,
    output okvt_pkg::t_stat              o_stat,
    input  logic [1:0]                   i_kind,
    input  logic [okvt_pkg::KEY_W-1:0]   i_key,
    input  logic [okvt_pkg::VAL_W-1:0]   i_value,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic                         o_found,
    output logic [okvt_pkg::VAL_W-1:0]   o_read_value,
    output logic                         o_table_full
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Entry cells, position 0 is the newest entry.
    logic [okvt_pkg::KEY_W-1:0] r_keys [TABLE_ENTRIES];
    logic [okvt_pkg::VAL_W-1:0] r_vals [TABLE_ENTRIES];
    logic [CW-1:0]              r_count;

    // Captured request.
    logic [1:0]                 r_kind;
    logic [okvt_pkg::KEY_W-1:0] r_key;
    logic [okvt_pkg::VAL_W-1:0] r_val;

    logic [TABLE_ENTRIES-1:0]   r_match;
    logic [TABLE_ENTRIES-1:0]   n_match;
    logic [TABLE_ENTRIES-1:0]   w_neg;
    logic [TABLE_ENTRIES-1:0]   w_first;
    logic [TABLE_ENTRIES-1:0]   w_ge;
    logic                       w_any;
    logic                       w_full;
    logic [okvt_pkg::VAL_W-1:0] w_hit_val;

    logic                       r_out_valid;
    logic                       r_found;
    logic [okvt_pkg::VAL_W-1:0] r_read_value;
    logic                       r_table_full;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_val  <= i_value;
        end
    end

    // Compare every occupied entry against the key.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_match[i] = (r_keys[i] == r_key) && (r_count > CW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) r_match <= n_match;
    end

    // Frontmost match and the positions at or behind it.
    assign w_neg   = ~r_match + TABLE_ENTRIES'(1);
    assign w_first = r_match & w_neg;
    assign w_ge    = r_match | w_neg;
    assign w_any   = |r_match;
    assign w_full  = (r_count == CW'(TABLE_ENTRIES));

    // Value of the frontmost match.
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_first[i]) w_hit_val = w_hit_val | r_vals[i];
        end
    end

    // Table update on execution.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_kind)
                okvt_pkg::KIND_INSERT: begin
                    if (!w_full) begin
                        for (int i = TABLE_ENTRIES - 1; i > 0; i--) begin
                            r_keys[i] <= r_keys[i-1];
                            r_vals[i] <= r_vals[i-1];
                        end
                        r_keys[0] <= r_key;
                        r_vals[0] <= r_val;
                    end
                end
                okvt_pkg::KIND_DELETE: begin
                    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                        if (w_ge[i] && w_any) begin
                            r_keys[i] <= r_keys[i+1];
                            r_vals[i] <= r_vals[i+1];
                        end
                    end
                end
                okvt_pkg::KIND_UPDATE: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (w_first[i]) r_vals[i] <= r_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if ((r_kind == okvt_pkg::KIND_INSERT) && !w_full) begin
                r_count <= r_count + CW'(1);
            end else if ((r_kind == okvt_pkg::KIND_DELETE) && w_any) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_found      <= w_any && (r_kind != okvt_pkg::KIND_INSERT);
            r_read_value <= (r_kind == okvt_pkg::KIND_FIND) ? w_hit_val : '0;
            r_table_full <= (r_kind == okvt_pkg::KIND_INSERT) && w_full;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_m_tvalid       = r_out_valid;
    assign o_found          = r_found;
    assign o_read_value     = r_read_value;
    assign o_table_full     = r_table_full;

    // A new result never overwrites one that is still waiting.
    `OKVT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_cmd.exec, !r_out_valid || i_m_tready)
    // The occupancy never exceeds the table size.
    `OKVT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_ENTRIES))
    // A refused insert reports nothing else.
    `OKVT_ASSERT_NOW(a_full_alone, i_clk, i_rst_n, r_out_valid && r_table_full,
        !r_found && (r_read_value == '0))
    // Execution always leaves a result in the output register.
    `OKVT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, i_cmd.exec, r_out_valid)

endmodule

// File: rtl/ordered_key_value_table_top.sv
// Top level of the ordered key-value table.
//
//  Channel   Dir  tdata                        tuser
//  s (req)   in   [31:0] key, [63:32] value    [1:0] kind
//  m (res)   out  [31:0] read_value            [0] found, [1] table_full
//
// Each request passes through two steps: registering the parallel key compare
// over all entries, then finding the frontmost match and applying the operation.
// A new request is accepted in the cycle the previous one executes, so back to
// back requests follow with no idle state between them while results are taken.
// A waiting result stalls execution until it is taken; no request is lost.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module ordered_key_value_table_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] key, [63:32] value
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] read_value
    output logic [1:0]  o_m_tuser    // [0] found, [1] table_full
);

    okvt_pkg::t_cmd  w_cmd;
    okvt_pkg::t_stat w_stat;
    logic            w_found;
    logic            w_table_full;

    // Sequencing of each request.
    okvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Entry storage, compare and result register.
    okvt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_kind       (i_s_tuser),
        .i_key        (i_s_tdata[31:0]),
        .i_value      (i_s_tdata[63:32]),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_found      (w_found),
        .o_read_value (o_m_tdata),
        .o_table_full (w_table_full)
    );

    assign o_m_tuser = {w_table_full, w_found};

endmodule
